>>> hw/rtl/bclru_pkg.sv
// package: constants, types and status codes of the buffer cache tag store
`default_nettype none
package bclru_pkg;
   localparam int NumBuffers = 64;
   localparam int CountBits  = 16;
   localparam int SlotBits   = 6;
   localparam int RankBits   = 6;
   localparam int TagBits    = 32;
   localparam logic [CountBits-1:0] CountMax = '1;

   typedef enum logic [2:0] {
      ST_HIT      = 3'd0,
      ST_MISS     = 3'd1,
      ST_EXHAUST  = 3'd2,
      ST_RELEASED = 3'd3,
      ST_HELD     = 3'd4,
      ST_BAD_PUT  = 3'd5,
      ST_OVERFLOW = 3'd6
   } status_type;

   typedef enum logic [2:0] {
      OP_NONE    = 3'd0,
      OP_HIT     = 3'd1,
      OP_FILL    = 3'd2,
      OP_EVICT   = 3'd3,
      OP_DEC     = 3'd4,
      OP_RELEASE = 3'd5
   } op_type;

   // broadcast command from the controller to every cell
   typedef struct packed {
      op_type               op;
      logic [SlotBits-1:0]  target;
      logic [TagBits-1:0]   file_id;
      logic [TagBits-1:0]   block_index;
      logic [RankBits-1:0]  rank;
   } cmd_type;

   // what one cell reports during lookup
   typedef struct packed {
      logic                 hit;
      logic                 valid;
      logic                 released;
      logic [RankBits-1:0]  rank;
      logic [CountBits-1:0] count;
   } cell_stat_type;

   typedef enum logic [1:0] {
      S_IDLE   = 2'd0,
      S_DECIDE = 2'd1,
      S_OUT    = 2'd2
   } state_type;
endpackage
`default_nettype wire

>>> hw/rtl/bclru_cell.sv
// one buffer slot: tag, count and release-order rank
`default_nettype none
module bclru_cell
   import bclru_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic [SlotBits-1:0] my_slot,
   input  wire logic [TagBits-1:0]  look_file,
   input  wire logic [TagBits-1:0]  look_block,
   input  wire cmd_type             cmd,
   output cell_stat_type            stat
);
   logic                 valid_ff, rel_ff;
   logic [RankBits-1:0]  rank_ff;
   logic [CountBits-1:0] count_ff;
   logic [TagBits-1:0]   file_ff, block_ff;
   logic                 me;

   assign me = (cmd.target == my_slot);
   assign stat.hit = valid_ff && file_ff == look_file && block_ff == look_block;
   assign stat.valid = valid_ff;
   assign stat.released = rel_ff;
   assign stat.rank = rank_ff;
   assign stat.count = count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         rel_ff   <= 1'b0;
         rank_ff  <= '0;
         count_ff <= '0;
      end else begin
         case (cmd.op)
            OP_HIT: begin
               if (me) begin
                  count_ff <= count_ff + 1'b1;
                  rel_ff   <= 1'b0;
                  rank_ff  <= '0;
               end else if (rel_ff && rank_ff > cmd.rank) begin
                  rank_ff <= rank_ff - 1'b1;
               end
            end
            OP_FILL, OP_EVICT: begin
               if (me) begin
                  valid_ff <= 1'b1;
                  count_ff <= {{(CountBits-1){1'b0}}, 1'b1};
                  rel_ff   <= 1'b0;
                  rank_ff  <= '0;
               end else if (rel_ff && rank_ff > cmd.rank) begin
                  rank_ff <= rank_ff - 1'b1;
               end
            end
            OP_DEC: begin
               if (me) count_ff <= count_ff - 1'b1;
            end
            OP_RELEASE: begin
               if (me) begin
                  count_ff <= '0;
                  rel_ff   <= 1'b1;
                  rank_ff  <= '0;
               end else if (rel_ff) begin
                  rank_ff <= rank_ff + 1'b1;
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if ((cmd.op == OP_FILL || cmd.op == OP_EVICT) && me) begin
         file_ff  <= cmd.file_id;
         block_ff <= cmd.block_index;
      end
   end
endmodule
`default_nettype wire

>>> hw/rtl/bclru_select.sv
// registered reduction over cell reports: hit, first empty, oldest released
`default_nettype none
module bclru_select
   import bclru_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire cmd_type       cmd,
   input  wire cell_stat_type stat [NumBuffers],
   output logic               hit_ff,
   output logic [SlotBits-1:0] hit_slot_ff,
   output logic [CountBits-1:0] hit_count_ff,
   output logic [RankBits-1:0] hit_rank_ff,
   output logic               hit_rel_ff,
   output logic               empty_ff,
   output logic [SlotBits-1:0] empty_slot_ff,
   output logic               old_ff,
   output logic [SlotBits-1:0] old_slot_ff,
   output logic [RankBits-1:0] old_rank_ff
);
   logic                 hit_in, empty_in, old_in, hit_rel_in;
   logic [SlotBits-1:0]  hit_slot_in, empty_slot_in, old_slot_in;
   logic [CountBits-1:0] hit_count_in;
   logic [RankBits-1:0]  hit_rank_in, old_rank_in;
   logic [RankBits:0]    rel_cnt_ff, rel_cnt_in;
   logic [RankBits:0]    old_rank_full;
   logic                 old_match;

   // released ranks always run 0 .. count-1, so the oldest holds rank count-1
   always_comb begin
      hit_in = 1'b0; hit_slot_in = '0; hit_count_in = '0;
      hit_rank_in = '0; hit_rel_in = 1'b0;
      empty_in = 1'b0; empty_slot_in = '0;
      old_in = 1'b0; old_slot_in = '0;
      old_match = 1'b0;
      old_rank_full = rel_cnt_ff - 1'b1;
      for (int i = NumBuffers - 1; i >= 0; i--) begin
         if (!stat[i].valid) begin
            empty_in = 1'b1;
            empty_slot_in = SlotBits'(i);
         end
      end
      for (int i = 0; i < NumBuffers; i++) begin
         if (stat[i].hit) begin
            hit_in = 1'b1;
            hit_slot_in = SlotBits'(i);
            hit_count_in = stat[i].count;
            hit_rank_in = stat[i].rank;
            hit_rel_in = stat[i].released;
         end
         old_match = stat[i].released && ({1'b0, stat[i].rank} == old_rank_full);
         old_in = old_in | old_match;
         old_slot_in = old_slot_in | ({SlotBits{old_match}} & SlotBits'(i));
      end
      old_rank_in = old_rank_full[RankBits-1:0];
   end

   // number of slots on the release order
   always_comb begin
      rel_cnt_in = rel_cnt_ff;
      case (cmd.op)
         OP_RELEASE: rel_cnt_in = rel_cnt_ff + 1'b1;
         OP_EVICT:   rel_cnt_in = rel_cnt_ff - 1'b1;
         OP_HIT: begin
            if (stat[cmd.target].released) rel_cnt_in = rel_cnt_ff - 1'b1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rel_cnt_ff <= '0;
      end else begin
         rel_cnt_ff <= rel_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      hit_ff <= hit_in; hit_slot_ff <= hit_slot_in; hit_count_ff <= hit_count_in;
      hit_rank_ff <= hit_rank_in; hit_rel_ff <= hit_rel_in;
      empty_ff <= empty_in; empty_slot_ff <= empty_slot_in;
      old_ff <= old_in; old_slot_ff <= old_slot_in; old_rank_ff <= old_rank_in;
   end
endmodule
`default_nettype wire

>>> hw/rtl/buffer_cache_lru_refcount.sv
// top level: tag store and lru replacement of a buffer cache with reference counts
// usage
//   req_ channel carries one request item: a get by (file_id, block_index)
//   or a put of a slot. rsp_ channel returns exactly one item per request:
//   status, slot_out, ref_count and replaced.
// sequence
//   an item is captured at the accepting edge; the slot cells are compared
//   in S_DECIDE and the reduction registered as it ends, and the result is
//   registered as S_OUT ends; the cells are updated at that same edge.
//   one item is in flight at a time; the next item is accepted only after
//   the result is taken, since the lookup and victim reduction across all
//   slots must finish before the dependent update.
// reset
//   synchronous, active high: all slots become never used with count zero
//   and the release order empties; tags are not cleared.
// stalls
//   the result stays in the output register until taken; a new request is
//   accepted once the result register is empty.
`default_nettype none
module buffer_cache_lru_refcount
   import bclru_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire logic                 req_type,
   input  wire logic [31:0]          req_file_id,
   input  wire logic [31:0]          req_block_index,
   input  wire logic [5:0]           req_slot,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output logic [2:0]                rsp_status,
   output logic [5:0]                rsp_slot_out,
   output logic [15:0]               rsp_ref_count,
   output logic                      rsp_replaced
);
   state_type state_ff, state_in;

   // captured request
   logic                 type_ff;
   logic [TagBits-1:0]   file_ff, block_ff;
   logic [SlotBits-1:0]  slot_ff;

   // result register
   logic                 rvalid_ff, rvalid_in;
   logic [2:0]           st_ff, st_in;
   logic [SlotBits-1:0]  so_ff, so_in;
   logic [CountBits-1:0] cnt_ff, cnt_in;
   logic                 rep_ff, rep_in;

   cmd_type       cmd;
   cell_stat_type stat [NumBuffers];

   logic                 hit, hit_rel, empty, old;
   logic [SlotBits-1:0]  hit_slot, empty_slot, old_slot;
   logic [CountBits-1:0] hit_count;
   logic [RankBits-1:0]  hit_rank, old_rank;
   cell_stat_type        put_stat;

   for (genvar g = 0; g < NumBuffers; g++) begin : g_cell
      bclru_cell u_cell (
         .clock, .reset,
         .my_slot    (SlotBits'(g)),
         .look_file  (file_ff),
         .look_block (block_ff),
         .cmd,
         .stat       (stat[g])
      );
   end

   bclru_select u_sel (
      .clock, .reset, .cmd, .stat,
      .hit_ff(hit), .hit_slot_ff(hit_slot), .hit_count_ff(hit_count),
      .hit_rank_ff(hit_rank), .hit_rel_ff(hit_rel),
      .empty_ff(empty), .empty_slot_ff(empty_slot),
      .old_ff(old), .old_slot_ff(old_slot), .old_rank_ff(old_rank)
   );

   // the put slot is read straight from its cell (mux indexed by the captured slot)
   assign put_stat = stat[slot_ff];

   assign req_ready = (state_ff == S_IDLE) && !rvalid_ff;

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         type_ff  <= req_type;
         file_ff  <= req_file_id;
         block_ff <= req_block_index;
         slot_ff  <= req_slot;
      end
      st_ff <= st_in; so_ff <= so_in; cnt_ff <= cnt_in; rep_ff <= rep_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         rvalid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         rvalid_ff <= rvalid_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      rvalid_in = rvalid_ff && !rsp_ready;
      st_in = st_ff; so_in = so_ff; cnt_in = cnt_ff; rep_in = rep_ff;
      cmd = '{op: OP_NONE, target: '0, file_id: file_ff, block_index: block_ff,
              rank: '0};
      case (state_ff)
         S_IDLE: begin
            if (req_valid && req_ready) state_in = S_DECIDE;
         end
         S_DECIDE: begin
            // cells compare against the captured tag; the reduction is registered as this state ends
            state_in = S_OUT;
         end
         S_OUT: begin
            state_in  = S_IDLE;
            rvalid_in = 1'b1;
            rep_in    = 1'b0;
            if (!type_ff) begin
               if (hit) begin
                  so_in = hit_slot;
                  if (hit_count == CountMax) begin
                     st_in = ST_OVERFLOW; cnt_in = hit_count;
                  end else begin
                     st_in = ST_HIT; cnt_in = hit_count + 1'b1;
                     cmd.op = OP_HIT; cmd.target = hit_slot;
                     // rank past all when not released: nobody shifts
                     cmd.rank = hit_rel ? hit_rank : '1;
                  end
               end else if (empty) begin
                  st_in = ST_MISS; so_in = empty_slot;
                  cnt_in = {{(CountBits-1){1'b0}}, 1'b1};
                  cmd.op = OP_FILL; cmd.target = empty_slot; cmd.rank = '1;
               end else if (old) begin
                  st_in = ST_MISS; so_in = old_slot; rep_in = 1'b1;
                  cnt_in = {{(CountBits-1){1'b0}}, 1'b1};
                  cmd.op = OP_EVICT; cmd.target = old_slot; cmd.rank = old_rank;
               end else begin
                  st_in = ST_EXHAUST; so_in = '0; cnt_in = '0;
               end
            end else begin
               so_in = slot_ff;
               if (!put_stat.valid || put_stat.count == '0) begin
                  st_in = ST_BAD_PUT; cnt_in = put_stat.count;
               end else if (put_stat.count == {{(CountBits-1){1'b0}}, 1'b1}) begin
                  st_in = ST_RELEASED; cnt_in = '0;
                  cmd.op = OP_RELEASE; cmd.target = slot_ff;
               end else begin
                  st_in = ST_HELD; cnt_in = put_stat.count - 1'b1;
                  cmd.op = OP_DEC; cmd.target = slot_ff;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign rsp_valid     = rvalid_ff;
   assign rsp_status    = st_ff;
   assign rsp_slot_out  = so_ff;
   assign rsp_ref_count = cnt_ff;
   assign rsp_replaced  = rep_ff;

   // a result must not be overwritten while waiting
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status))
      else $error("result lost while stalled");
   // no new item while a request is in flight
   a_one: assert property (@(posedge clock) disable iff (reset)
      state_ff != S_IDLE |-> !req_ready)
      else $error("accepted while busy");
   // replaced only on a miss fill
   a_rep: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_replaced |-> rsp_status == ST_MISS)
      else $error("replaced without miss");
endmodule
`default_nettype wire

>>> sim/testbench.sv
// testbench for the buffer cache tag store: directed table, fill, release and random traffic
`default_nettype none
module testbench;
   import bclru_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   // one request item and one response item as the predictor sees them
   typedef struct {
      logic        op;
      logic [31:0] file_id;
      logic [31:0] block_index;
      logic [5:0]  slot;
   } request_type;

   typedef struct {
      status_type  status;
      logic [5:0]  slot_out;
      logic [15:0] ref_count;
      logic        replaced;
   } answer_type;

   // a directed row; typed rows carry the answer written by hand
   typedef struct {
      request_type rq;
      bit          typed;
      answer_type  ans;
   } row_type;

   localparam logic OP_GET = 1'b0;
   localparam logic OP_PUT = 1'b1;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic        req_type;
   logic [31:0] req_file_id;
   logic [31:0] req_block_index;
   logic [5:0]  req_slot;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [2:0]  rsp_status;
   logic [5:0]  rsp_slot_out;
   logic [15:0] rsp_ref_count;
   logic        rsp_replaced;

   buffer_cache_lru_refcount u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_type        (req_type),
      .req_file_id     (req_file_id),
      .req_block_index (req_block_index),
      .req_slot        (req_slot),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_status      (rsp_status),
      .rsp_slot_out    (rsp_slot_out),
      .rsp_ref_count   (rsp_ref_count),
      .rsp_replaced    (rsp_replaced)
   );

   // shadow copy of the tag store
   logic                 slot_used [NumBuffers];
   logic [31:0]          file_of   [NumBuffers];
   logic [31:0]          block_of  [NumBuffers];
   logic [CountBits-1:0] holds     [NumBuffers];
   logic                 released  [NumBuffers];
   int                   age       [NumBuffers];

   answer_type  pending_answers[$];
   int          mismatches;
   int          seen_status [8];
   bit          burst;        // no idling on either side while set
   request_type tag_pool [80];

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // generous bound: roughly ten times the longest run with full idling
   initial begin
      #5_000_000;
      $display("testbench: FAIL");
      $finish;
   end

   // drop a slot from the release order, closing the gap behind it
   function automatic void unlink_slot(int s);
      for (int j = 0; j < NumBuffers; j++)
         if (released[j] && j != s && age[j] > age[s]) age[j]--;
      released[s] = 1'b0;
      age[s] = 0;
   endfunction

   function automatic answer_type cache_access(request_type rq);
      answer_type a;
      int         victim;
      int         best;
      a = '{status: ST_HIT, slot_out: '0, ref_count: '0, replaced: 1'b0};
      victim = -1;
      best = 0;
      if (rq.op == OP_GET) begin
         for (int i = 0; i < NumBuffers; i++) begin
            if (slot_used[i] && file_of[i] == rq.file_id && block_of[i] == rq.block_index) begin
               a.slot_out = i[5:0];
               if (holds[i] == CountMax) begin
                  a.status = ST_OVERFLOW;
                  a.ref_count = holds[i];
                  return a;
               end
               // a hit on a released buffer takes it out of the order
               if (released[i]) unlink_slot(i);
               holds[i]++;
               a.ref_count = holds[i];
               return a;
            end
         end
         for (int i = 0; i < NumBuffers && victim < 0; i++)
            if (!slot_used[i]) victim = i;
         if (victim < 0) begin
            // oldest released buffer is the lru victim
            for (int i = 0; i < NumBuffers; i++)
               if (released[i] && (victim < 0 || age[i] > best)) begin
                  victim = i;
                  best = age[i];
               end
            if (victim < 0) begin
               a.status = ST_EXHAUST;
               return a;
            end
            unlink_slot(victim);
            a.replaced = 1'b1;
         end
         slot_used[victim] = 1'b1;
         file_of[victim] = rq.file_id;
         block_of[victim] = rq.block_index;
         holds[victim] = 16'd1;
         a.status = ST_MISS;
         a.slot_out = victim[5:0];
         a.ref_count = 16'd1;
      end else begin
         a.slot_out = rq.slot;
         if (!slot_used[rq.slot] || holds[rq.slot] == 0) begin
            a.status = ST_BAD_PUT;
            a.ref_count = holds[rq.slot];
            return a;
         end
         holds[rq.slot]--;
         a.ref_count = holds[rq.slot];
         if (holds[rq.slot] == 0) begin
            for (int j = 0; j < NumBuffers; j++)
               if (released[j]) age[j]++;
            released[rq.slot] = 1'b1;
            age[rq.slot] = 0;
            a.status = ST_RELEASED;
         end else begin
            a.status = ST_HELD;
         end
      end
      return a;
   endfunction

   function automatic request_type get_req(logic [31:0] f, logic [31:0] b);
      return '{op: OP_GET, file_id: f, block_index: b, slot: '0};
   endfunction

   function automatic request_type put_req(logic [5:0] s);
      // tag fields carry noise on puts, the block ignores them
      return '{op: OP_PUT, file_id: $urandom, block_index: $urandom, slot: s};
   endfunction

   function automatic row_type row(request_type rq, bit typed, status_type st,
                                   logic [5:0] s, logic [15:0] c, logic r);
      return '{rq: rq, typed: typed,
               ans: '{status: st, slot_out: s, ref_count: c, replaced: r}};
   endfunction

   task automatic report_mismatch(string what, int expv, int gotv);
      $display("mismatch %s: expected %0d got %0d at %0t", what, expv, gotv, $realtime);
      mismatches++;
   endtask

   // present one item, hold it until taken, queue its answer
   task automatic send_item(request_type rq, bit typed, answer_type typed_ans);
      int         gap;
      answer_type a;
      gap = burst ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_type        <= rq.op;
      req_file_id     <= rq.file_id;
      req_block_index <= rq.block_index;
      req_slot        <= rq.slot;
      do @(posedge clock); while (!(req_valid && req_ready === 1'b1));
      // predictor always runs so its state tracks the block
      a = cache_access(rq);
      pending_answers.push_back(typed ? typed_ans : a);
   endtask

   task automatic send_predicted(request_type rq);
      answer_type none;
      none = '{status: ST_HIT, slot_out: '0, ref_count: '0, replaced: 1'b0};
      send_item(rq, 1'b0, none);
   endtask

   // response side: random stall per item, compare against oldest answer
   initial begin
      int         stall;
      answer_type e;
      rsp_ready = 1'b0;
      forever begin
         stall = burst ? 0 : $urandom_range(0, 8);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_valid === 1'b1 && rsp_ready));
         if (pending_answers.size() == 0) begin
            report_mismatch("unexpected item, status", -1, rsp_status);
         end else begin
            e = pending_answers.pop_front();
            seen_status[rsp_status]++;
            if (rsp_status !== e.status) report_mismatch("status", e.status, rsp_status);
            if (rsp_slot_out !== e.slot_out) report_mismatch("slot_out", e.slot_out, rsp_slot_out);
            if (rsp_ref_count !== e.ref_count)
               report_mismatch("ref_count", e.ref_count, rsp_ref_count);
            if (rsp_replaced !== e.replaced) report_mismatch("replaced", e.replaced, rsp_replaced);
         end
      end
   end

   initial begin
      row_type     rows[$];
      request_type rq;
      int          pick;
      int          held_slot;
      int          n;
      mismatches = 0;
      burst = 1'b0;
      for (int i = 0; i < 8; i++) seen_status[i] = 0;
      for (int i = 0; i < NumBuffers; i++) begin
         slot_used[i] = 1'b0;
         file_of[i] = '0;
         block_of[i] = '0;
         holds[i] = '0;
         released[i] = 1'b0;
         age[i] = 0;
      end
      req_valid = 1'b0;
      req_type = 1'b0;
      req_file_id = '0;
      req_block_index = '0;
      req_slot = '0;
      reset = 1'b1;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table: values after reset and at the field extremes typed in
      rows.push_back(row(put_req(6'd0), 1, ST_BAD_PUT, 6'd0, 16'd0, 1'b0));
      rows.push_back(row(put_req(6'd63), 1, ST_BAD_PUT, 6'd63, 16'd0, 1'b0));
      rows.push_back(row(get_req(32'h0, 32'h0), 1, ST_MISS, 6'd0, 16'd1, 1'b0));
      rows.push_back(row(get_req('1, '1), 1, ST_MISS, 6'd1, 16'd1, 1'b0));
      rows.push_back(row(get_req(32'h0, 32'h0), 1, ST_HIT, 6'd0, 16'd2, 1'b0));
      rows.push_back(row(put_req(6'd0), 1, ST_HELD, 6'd0, 16'd1, 1'b0));
      rows.push_back(row(put_req(6'd0), 1, ST_RELEASED, 6'd0, 16'd0, 1'b0));
      // put on a slot already at zero
      rows.push_back(row(put_req(6'd0), 1, ST_BAD_PUT, 6'd0, 16'd0, 1'b0));
      // hit on a released buffer brings it back with one holder
      rows.push_back(row(get_req(32'h0, 32'h0), 1, ST_HIT, 6'd0, 16'd1, 1'b0));
      rows.push_back(row(get_req(32'h0, '1), 1, ST_MISS, 6'd2, 16'd1, 1'b0));
      rows.push_back(row(get_req('1, 32'h0), 1, ST_MISS, 6'd3, 16'd1, 1'b0));
      // tags differing in one half only must not hit
      rows.push_back(row(get_req(32'h0, 32'h1), 0, ST_HIT, 6'd0, 16'd0, 1'b0));
      rows.push_back(row(get_req(32'h8000_0000, 32'h0), 0, ST_HIT, 6'd0, 16'd0, 1'b0));
      rows.push_back(row(put_req(6'd3), 0, ST_HIT, 6'd0, 16'd0, 1'b0));
      rows.push_back(row(put_req(6'd2), 0, ST_HIT, 6'd0, 16'd0, 1'b0));
      rows.push_back(row(put_req(6'd1), 0, ST_HIT, 6'd0, 16'd0, 1'b0));
      rows.push_back(row(put_req(6'd40), 0, ST_HIT, 6'd0, 16'd0, 1'b0));
      foreach (rows[i]) send_item(rows[i].rq, rows[i].typed, rows[i].ans);

      // fill every slot with fresh tags: lru evictions then exhaustion
      for (int i = 0; i < 70; i++) send_predicted(get_req($urandom, $urandom));
      // release everything once so the order fills up
      for (int i = 0; i < NumBuffers; i++) send_predicted(put_req(i[5:0]));

      for (int i = 0; i < 80; i++) tag_pool[i] = get_req($urandom, $urandom);

      // random traffic: mostly gets from a reusable pool and puts on held slots
      for (int i = 0; i < 1650; i++) begin
         if (i % 150 == 0) burst = ($urandom_range(0, 3) == 0);
         pick = $urandom_range(0, 99);
         if (pick < 50) begin
            rq = tag_pool[$urandom_range(0, 79)];
         end else if (pick < 56) begin
            rq = get_req($urandom, $urandom);
         end else if (pick < 90) begin
            // a held slot most of the time
            held_slot = $urandom_range(0, NumBuffers - 1);
            n = 0;
            while (holds[held_slot] == 0 && n < NumBuffers) begin
               held_slot = (held_slot + 1) % NumBuffers;
               n++;
            end
            rq = put_req(held_slot[5:0]);
         end else begin
            rq = put_req(6'($urandom_range(0, 63)));
         end
         send_predicted(rq);
      end
      req_valid <= 1'b0;
      burst = 1'b0;

      while (pending_answers.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      $display("covered hits %0d, misses %0d, exhausted %0d, released %0d",
               seen_status[ST_HIT], seen_status[ST_MISS], seen_status[ST_EXHAUST],
               seen_status[ST_RELEASED]);
      $display("held %0d, bad puts %0d, overflows %0d, mismatches %0d",
               seen_status[ST_HELD], seen_status[ST_BAD_PUT], seen_status[ST_OVERFLOW],
               mismatches);
      if (mismatches == 0 && pending_answers.size() == 0) begin
         $display("testbench: PASS");
      end else begin
         $display("testbench: FAIL");
      end
      $finish;
   end
endmodule
`default_nettype wire
